// File: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, constants and step codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam int unsigned HDR_BYTES   = 12;
    localparam int unsigned MIN_REQ     = 8;
    localparam int unsigned ROUND_ADD   = 15;
    localparam int unsigned SPLIT_SLACK = 20;
    localparam int unsigned HEAP_MIN    = 24;
    localparam int unsigned HEAP_RESET  = 65536;
    localparam int unsigned ARG_W       = 16;
    localparam int unsigned NEED_W      = 17;
    localparam int unsigned CFG_W       = 17;
    localparam int unsigned STEP_W      = 5;

    localparam logic [STEP_W-1:0] ST_CLR     = 5'd0;
    localparam logic [STEP_W-1:0] ST_INIT    = 5'd1;
    localparam logic [STEP_W-1:0] ST_IDLE    = 5'd2;
    localparam logic [STEP_W-1:0] ST_A_RD    = 5'd3;
    localparam logic [STEP_W-1:0] ST_A_CHK   = 5'd4;
    localparam logic [STEP_W-1:0] ST_S_HDR   = 5'd5;
    localparam logic [STEP_W-1:0] ST_S_NEXT  = 5'd6;
    localparam logic [STEP_W-1:0] ST_U_RD    = 5'd7;
    localparam logic [STEP_W-1:0] ST_U_WR    = 5'd8;
    localparam logic [STEP_W-1:0] ST_F_START = 5'd9;
    localparam logic [STEP_W-1:0] ST_F_CHK   = 5'd10;
    localparam logic [STEP_W-1:0] ST_F_PRE   = 5'd11;
    localparam logic [STEP_W-1:0] ST_F_LNK   = 5'd12;
    localparam logic [STEP_W-1:0] ST_F_TAIL  = 5'd13;
    localparam logic [STEP_W-1:0] ST_G_RD    = 5'd14;
    localparam logic [STEP_W-1:0] ST_G_CHK   = 5'd15;
    localparam logic [STEP_W-1:0] ST_DONE    = 5'd16;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              accept;
        logic              cfg_take;
        logic              is_alloc;
    } t_cmd;

    typedef struct packed {
        logic x_nil;
        logic fit;
        logic split;
        logic free_bad;
        logic blk_used;
        logic off_zero;
        logic succ_in;
        logic clr_last;
        logic out_room;
    } t_stat;

    function automatic logic [NEED_W-1:0] need_bytes(input logic [ARG_W-1:0] n);
        logic [NEED_W-1:0] m;
        m = (n < ARG_W'(MIN_REQ)) ? NEED_W'(MIN_REQ) : NEED_W'(n);
        m = m + NEED_W'(ROUND_ADD);
        return {m[NEED_W-1:2], 2'b00};
    endfunction

endpackage

// File: rtl/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with a doubly linked free list and coalescing.
// ----------------------------------------------------------------------------
// Input words on s_axis: operation (alloc, free, query) in tuser and a size or
// payload offset in tdata. One result word per input on m_axis: payload offset
// and ok flag. The cfg channel writes the heap size and rebuilds the heap.
// Headers live in five RAMs indexed by block offset / 4, with a shared read address.
// Alloc and query walk the free list from the head, a read step and a check
// step per visited header, until a block fits or the list runs out. Alloc
// then splits the block when the slack exceeds SPLIT_SLACK and unlinks it;
// free merges the block into a free predecessor or appends it to the list,
// then merges in a free successor. The result goes to the output register.
// One word is in work at a time; the next input is taken once the result is
// in the output register, even while m_axis is stalled. A stalled m_axis
// holds the result and blocks only the following completion.
// After reset and after each cfg write the used marks are cleared, one entry
// per cycle, then one free block is written; s_axis and cfg stay not ready.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES_MAX = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // amount_or_offset[15:0]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // payload_offset[15:0], ok[16]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data      // heap_bytes[16:0]
);
    ffa_pkg::t_cmd  cmd;
    ffa_pkg::t_stat stat;
    logic [15:0]    out_pay;
    logic           out_ok;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready),
        .o_cfg_ready(o_cfg_ready)
    );

    ffa_dpath #(.HEAP_BYTES_MAX(HEAP_BYTES_MAX)) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_arg      (s_axis_tdata),
        .i_cfg_data (i_cfg_data),
        .i_out_ready(m_axis_tready),
        .o_stat     (stat),
        .o_out_valid(m_axis_tvalid),
        .o_out_pay  (out_pay),
        .o_out_ok   (out_ok)
    );

    assign m_axis_tdata = {7'b0, out_ok, out_pay};
endmodule

// File: rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: steps alloc, free and query through header reads and writes.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_op,
    input  logic          i_cfg_valid,
    input  ffa_pkg::t_stat i_stat,
    output ffa_pkg::t_cmd  o_cmd,
    output logic          o_in_ready,
    output logic          o_cfg_ready
);
    logic [ffa_pkg::STEP_W-1:0] r_state, n_state;
    logic                       r_alloc, n_alloc;
    logic                       in_take, cfg_take;

    assign o_cfg_ready = (r_state == ffa_pkg::ST_IDLE);
    assign o_in_ready  = (r_state == ffa_pkg::ST_IDLE) && !i_cfg_valid;
    assign cfg_take    = o_cfg_ready && i_cfg_valid;
    assign in_take     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_alloc = r_alloc;
        case (r_state)
            ffa_pkg::ST_CLR: begin
                if (i_stat.clr_last) n_state = ffa_pkg::ST_INIT;
            end
            ffa_pkg::ST_INIT: n_state = ffa_pkg::ST_IDLE;
            ffa_pkg::ST_IDLE: begin
                if (cfg_take) begin
                    n_state = ffa_pkg::ST_CLR;
                end else if (in_take) begin
                    n_alloc = (i_in_op == ffa_pkg::OP_ALLOC);
                    case (i_in_op)
                        ffa_pkg::OP_ALLOC: n_state = ffa_pkg::ST_A_RD;
                        ffa_pkg::OP_QUERY: n_state = ffa_pkg::ST_A_RD;
                        ffa_pkg::OP_FREE:  n_state = ffa_pkg::ST_F_START;
                        default:           n_state = ffa_pkg::ST_DONE;
                    endcase
                end
            end
            ffa_pkg::ST_A_RD: begin
                n_state = i_stat.x_nil ? ffa_pkg::ST_DONE : ffa_pkg::ST_A_CHK;
            end
            ffa_pkg::ST_A_CHK: begin
                if (!i_stat.fit) n_state = ffa_pkg::ST_A_RD;
                else if (!r_alloc) n_state = ffa_pkg::ST_DONE;
                else if (i_stat.split) n_state = ffa_pkg::ST_S_HDR;
                else n_state = ffa_pkg::ST_U_RD;
            end
            ffa_pkg::ST_S_HDR:  n_state = ffa_pkg::ST_S_NEXT;
            ffa_pkg::ST_S_NEXT: n_state = ffa_pkg::ST_U_RD;
            ffa_pkg::ST_U_RD:   n_state = ffa_pkg::ST_U_WR;
            ffa_pkg::ST_U_WR:   n_state = ffa_pkg::ST_DONE;
            ffa_pkg::ST_F_START: begin
                n_state = i_stat.free_bad ? ffa_pkg::ST_DONE : ffa_pkg::ST_F_CHK;
            end
            ffa_pkg::ST_F_CHK: begin
                if (!i_stat.blk_used) n_state = ffa_pkg::ST_DONE;
                else if (i_stat.off_zero) n_state = ffa_pkg::ST_F_LNK;
                else n_state = ffa_pkg::ST_F_PRE;
            end
            ffa_pkg::ST_F_PRE: begin
                n_state = i_stat.blk_used ? ffa_pkg::ST_F_LNK : ffa_pkg::ST_G_RD;
            end
            ffa_pkg::ST_F_LNK:  n_state = ffa_pkg::ST_F_TAIL;
            ffa_pkg::ST_F_TAIL: n_state = ffa_pkg::ST_G_RD;
            ffa_pkg::ST_G_RD: begin
                n_state = i_stat.succ_in ? ffa_pkg::ST_G_CHK : ffa_pkg::ST_DONE;
            end
            ffa_pkg::ST_G_CHK: begin
                n_state = i_stat.blk_used ? ffa_pkg::ST_DONE : ffa_pkg::ST_U_WR;
            end
            ffa_pkg::ST_DONE: begin
                if (i_stat.out_room) n_state = ffa_pkg::ST_IDLE;
            end
            default: n_state = ffa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::ST_CLR;
            r_alloc <= 1'b0;
        end else begin
            r_state <= n_state;
            r_alloc <= n_alloc;
        end
    end

    assign o_cmd.step     = r_state;
    assign o_cmd.accept   = in_take;
    assign o_cmd.cfg_take = cfg_take;
    assign o_cmd.is_alloc = r_alloc;
endmodule

// File: rtl/ffa_dpath.sv
// ----------------------------------------------------------------------------
// ffa_dpath
// Header stores, free-list head and tail, walk registers and result register.
// ----------------------------------------------------------------------------
module ffa_dpath #(
    parameter int HEAP_BYTES_MAX = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ffa_pkg::t_cmd                  i_cmd,
    input  logic [ffa_pkg::ARG_W-1:0]      i_arg,
    input  logic [ffa_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_out_ready,
    output ffa_pkg::t_stat                 o_stat,
    output logic                           o_out_valid,
    output logic [15:0]                    o_out_pay,
    output logic                           o_out_ok
);
    localparam int DEPTH = HEAP_BYTES_MAX / 4;
    localparam int IW    = $clog2(DEPTH);
    localparam int PW    = IW + 1;
    localparam int HW    = $clog2(HEAP_BYTES_MAX) + 1;
    localparam int SW    = (HW > 17) ? HW : 17;
    localparam int AW    = (HW > 16) ? HW : 16;
    localparam int RST_HEAP = (ffa_pkg::HEAP_RESET > HEAP_BYTES_MAX) ?
                              HEAP_BYTES_MAX : ffa_pkg::HEAP_RESET;
    localparam logic [PW-1:0] NIL = {1'b1, {IW{1'b0}}};

    logic [HW-1:0]  r_heap;
    logic [15:0]    r_arg;
    logic [16:0]    r_need;
    logic [PW-1:0]  r_x, r_head, r_tail;
    logic [IW-1:0]  r_b, r_p, r_cur, r_u, r_cnt;
    logic [HW-1:0]  r_bsize, r_succ, r_cursize;
    logic           r_ok;
    logic [15:0]    r_pay;
    logic           r_out_valid, r_out_ok;
    logic [15:0]    r_out_pay;

    logic [IW-1:0]  raddr;
    logic           size_we, pprev_we, alloc_we, fnext_we, fprev_we;
    logic [IW-1:0]  size_wa, pprev_wa, alloc_wa, fnext_wa, fprev_wa;
    logic [HW-1:0]  size_wd;
    logic [IW-1:0]  pprev_wd;
    logic           alloc_wd;
    logic [PW-1:0]  fnext_wd, fprev_wd;
    logic [HW-1:0]  size_q;
    logic [IW-1:0]  pprev_q;
    logic           alloc_q;
    logic [PW-1:0]  fnext_q, fprev_q;

    logic [SW-1:0]  slack, cfg_ext;
    logic [HW-1:0]  off_b, noff, nsize, after, t_off, need_h;
    logic [IW-1:0]  nb, s_idx, b_arg;
    logic [AW-1:0]  off_arg;
    logic           fit, split, bad, after_in, t_in;
    logic [HW-1:0]  cfg_heap;

    ffa_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_size (
        .i_clk(i_clk), .i_we(size_we), .i_waddr(size_wa), .i_wdata(size_wd),
        .i_raddr(raddr), .o_rdata(size_q));
    ffa_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_pprev (
        .i_clk(i_clk), .i_we(pprev_we), .i_waddr(pprev_wa), .i_wdata(pprev_wd),
        .i_raddr(raddr), .o_rdata(pprev_q));
    ffa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_alloc (
        .i_clk(i_clk), .i_we(alloc_we), .i_waddr(alloc_wa), .i_wdata(alloc_wd),
        .i_raddr(raddr), .o_rdata(alloc_q));
    ffa_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_fnext (
        .i_clk(i_clk), .i_we(fnext_we), .i_waddr(fnext_wa), .i_wdata(fnext_wd),
        .i_raddr(raddr), .o_rdata(fnext_q));
    ffa_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_fprev (
        .i_clk(i_clk), .i_we(fprev_we), .i_waddr(fprev_wa), .i_wdata(fprev_wd),
        .i_raddr(raddr), .o_rdata(fprev_q));

    assign slack    = SW'(size_q) - SW'(r_need);
    assign fit      = SW'(size_q) >= SW'(r_need);
    assign split    = slack > SW'(ffa_pkg::SPLIT_SLACK);
    assign need_h   = HW'(r_need);
    assign off_b    = HW'({r_b, 2'b00});
    assign noff     = off_b + need_h;
    assign nb       = noff[IW+1:2];
    assign nsize    = r_bsize - need_h;
    assign after    = off_b + r_bsize;
    assign after_in = after < r_heap;
    assign off_arg  = AW'(r_arg) - AW'(ffa_pkg::HDR_BYTES);
    assign bad      = (r_arg < 16'(ffa_pkg::HDR_BYTES)) || (off_arg[1:0] != 2'b00) ||
                      (off_arg >= AW'(r_heap));
    assign b_arg    = off_arg[IW+1:2];
    assign s_idx    = r_succ[IW+1:2];
    assign t_off    = r_succ + size_q;
    assign t_in     = t_off < r_heap;
    assign cfg_ext  = SW'(i_cfg_data);
    assign cfg_heap = (cfg_ext < SW'(ffa_pkg::HEAP_MIN)) ? HW'(ffa_pkg::HEAP_MIN) :
                      (cfg_ext > SW'(HEAP_BYTES_MAX)) ? HW'(HEAP_BYTES_MAX) :
                      HW'(cfg_ext);

    always_comb begin
        raddr = r_u;
        case (i_cmd.step)
            ffa_pkg::ST_A_RD:    raddr = r_x[IW-1:0];
            ffa_pkg::ST_F_START: raddr = b_arg;
            ffa_pkg::ST_F_CHK:   raddr = pprev_q;
            ffa_pkg::ST_G_RD:    raddr = s_idx;
            ffa_pkg::ST_G_CHK:   raddr = s_idx;
            default:             raddr = r_u;
        endcase
    end

    always_comb begin
        size_we  = 1'b0; size_wa  = r_b; size_wd  = need_h;
        pprev_we = 1'b0; pprev_wa = nb;  pprev_wd = r_b;
        alloc_we = 1'b0; alloc_wa = r_b; alloc_wd = 1'b0;
        fnext_we = 1'b0; fnext_wa = r_b; fnext_wd = NIL;
        fprev_we = 1'b0; fprev_wa = r_b; fprev_wd = r_tail;
        case (i_cmd.step)
            ffa_pkg::ST_CLR: begin
                alloc_we = 1'b1; alloc_wa = r_cnt;
            end
            ffa_pkg::ST_INIT: begin
                size_we = 1'b1; size_wa = '0; size_wd = r_heap;
                fnext_we = 1'b1; fnext_wa = '0;
                fprev_we = 1'b1; fprev_wa = '0; fprev_wd = NIL;
            end
            ffa_pkg::ST_S_HDR: begin
                pprev_we = 1'b1;
                size_we = 1'b1; size_wa = nb; size_wd = nsize;
                alloc_we = 1'b1; alloc_wa = nb;
                fnext_we = 1'b1; fnext_wa = nb;
                fprev_we = 1'b1; fprev_wa = nb;
            end
            ffa_pkg::ST_S_NEXT: begin
                size_we = 1'b1;
                pprev_we = after_in; pprev_wa = after[IW+1:2]; pprev_wd = nb;
                fnext_we = !r_tail[IW]; fnext_wa = r_tail[IW-1:0];
                fnext_wd = {1'b0, nb};
            end
            ffa_pkg::ST_F_PRE: begin
                if (!alloc_q) begin
                    size_we = 1'b1; size_wa = r_p; size_wd = size_q + r_bsize;
                    alloc_we = 1'b1;
                    pprev_we = (r_succ < r_heap); pprev_wa = s_idx; pprev_wd = r_p;
                end
            end
            ffa_pkg::ST_F_LNK: begin
                fnext_we = 1'b1;
                fprev_we = 1'b1;
                alloc_we = 1'b1;
            end
            ffa_pkg::ST_F_TAIL: begin
                fnext_we = !r_tail[IW]; fnext_wa = r_tail[IW-1:0];
                fnext_wd = {1'b0, r_b};
            end
            ffa_pkg::ST_G_CHK: begin
                if (!alloc_q) begin
                    size_we = 1'b1; size_wa = r_cur; size_wd = r_cursize + size_q;
                    pprev_we = t_in; pprev_wa = t_off[IW+1:2]; pprev_wd = r_cur;
                end
            end
            ffa_pkg::ST_U_WR: begin
                fnext_we = !fprev_q[IW]; fnext_wa = fprev_q[IW-1:0]; fnext_wd = fnext_q;
                fprev_we = !fnext_q[IW]; fprev_wa = fnext_q[IW-1:0]; fprev_wd = fprev_q;
                alloc_we = i_cmd.is_alloc; alloc_wa = r_u; alloc_wd = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap      <= HW'(RST_HEAP);
            r_cnt       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((i_cmd.step == ffa_pkg::ST_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.step)
                ffa_pkg::ST_CLR: r_cnt <= r_cnt + 1'b1;
                ffa_pkg::ST_INIT: begin
                    r_head <= '0;
                    r_tail <= '0;
                end
                ffa_pkg::ST_IDLE: begin
                    if (i_cmd.cfg_take) begin
                        r_heap <= cfg_heap;
                        r_cnt  <= '0;
                    end
                end
                ffa_pkg::ST_S_NEXT: begin
                    if (r_tail[IW]) r_head <= {1'b0, nb};
                    r_tail <= {1'b0, nb};
                end
                ffa_pkg::ST_F_TAIL: begin
                    if (r_tail[IW]) r_head <= {1'b0, r_b};
                    r_tail <= {1'b0, r_b};
                end
                ffa_pkg::ST_U_WR: begin
                    if (fprev_q[IW]) r_head <= fnext_q;
                    if (fnext_q[IW]) r_tail <= fprev_q;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.step)
            ffa_pkg::ST_IDLE: begin
                if (i_cmd.accept) begin
                    r_arg  <= i_arg;
                    r_need <= ffa_pkg::need_bytes(i_arg);
                    r_x    <= r_head;
                    r_ok   <= 1'b0;
                    r_pay  <= '0;
                end
            end
            ffa_pkg::ST_A_CHK: begin
                if (fit) begin
                    r_b     <= r_x[IW-1:0];
                    r_u     <= r_x[IW-1:0];
                    r_bsize <= size_q;
                    if (!i_cmd.is_alloc) r_ok <= 1'b1;
                end else begin
                    r_x <= fnext_q;
                end
            end
            ffa_pkg::ST_F_START: r_b <= b_arg;
            ffa_pkg::ST_F_CHK: begin
                r_bsize <= size_q;
                r_p     <= pprev_q;
                r_succ  <= off_b + size_q;
                if (alloc_q) r_ok <= 1'b1;
            end
            ffa_pkg::ST_F_PRE: begin
                if (!alloc_q) begin
                    r_cur     <= r_p;
                    r_cursize <= size_q + r_bsize;
                end
            end
            ffa_pkg::ST_F_LNK: begin
                r_cur     <= r_b;
                r_cursize <= r_bsize;
            end
            ffa_pkg::ST_G_CHK: r_u <= s_idx;
            ffa_pkg::ST_U_WR: begin
                if (i_cmd.is_alloc) begin
                    r_ok  <= 1'b1;
                    r_pay <= 16'(AW'({r_u, 2'b00}) + AW'(ffa_pkg::HDR_BYTES));
                end
            end
            ffa_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_ok  <= r_ok;
                    r_out_pay <= r_pay;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.x_nil    = r_x[IW];
    assign o_stat.fit      = fit;
    assign o_stat.split    = split;
    assign o_stat.free_bad = bad;
    assign o_stat.blk_used = alloc_q;
    assign o_stat.off_zero = (r_b == '0);
    assign o_stat.succ_in  = r_succ < r_heap;
    assign o_stat.clr_last = (r_cnt == IW'(DEPTH - 1));
    assign o_stat.out_room = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_pay   = r_out_pay;
    assign o_out_ok    = r_out_ok;
endmodule

// File: verif/first_fit_heap_allocator_core_test.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core_test
// Checks the first-fit heap allocator against a predictor of its heap.
// Alloc, free and query words go in on s_axis, and each result word is
// compared with the predicted payload offset and ok flag. The heap size is
// rewritten between phases. Both streams idle in random bursts until the last quiet phase.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOT_CNT  = 65536 / 4 + 1;
    localparam int unsigned NIL       = 32'hFFFF_FFFF;
    localparam logic [1:0]  OP_BAD    = 2'd3;
    localparam int          LIMIT     = 10_000_000;

    class heap_scoreboard;
        int unsigned heap_bytes;
        int unsigned blk_size [SLOT_CNT];
        int unsigned phys_prev[SLOT_CNT];
        bit          in_use   [SLOT_CNT];
        int unsigned link_next[SLOT_CNT];
        int unsigned link_prev[SLOT_CNT];
        bit          is_start [SLOT_CNT];
        int unsigned head, tail;
        logic [16:0] pending[$];
        int unsigned live[$];
        int          errors;

        function new();
            errors = 0;
            foreach (blk_size[i]) begin
                blk_size[i] = 0; phys_prev[i] = 0; in_use[i] = 0;
                link_next[i] = 0; link_prev[i] = 0; is_start[i] = 0;
            end
            heap_bytes = 65536;
            rebuild();
        endfunction

        function void append(int unsigned x);
            link_next[x] = NIL;
            link_prev[x] = tail;
            if (tail == NIL) head = x;
            else link_next[tail] = x;
            tail = x;
        endfunction

        function void unlink(int unsigned x);
            int unsigned p, n;
            p = link_prev[x];
            n = link_next[x];
            if (p == NIL) head = n;
            else link_next[p] = n;
            if (n == NIL) tail = p;
            else link_prev[n] = p;
        endfunction

        function void rebuild();
            blk_size[0] = heap_bytes;
            phys_prev[0] = 0;
            in_use[0] = 0;
            is_start[0] = 1;
            head = NIL;
            tail = NIL;
            append(0);
            live.delete();
        endfunction

        function void set_heap(logic [16:0] v);
            int unsigned w;
            w = v;
            if (w < ffa_pkg::HEAP_MIN) w = ffa_pkg::HEAP_MIN;
            if (w > 65536) w = 65536;
            foreach (is_start[i]) is_start[i] = 0;
            heap_bytes = w;
            rebuild();
        endfunction

        function int unsigned size_for(int unsigned n);
            if (n < ffa_pkg::MIN_REQ) n = ffa_pkg::MIN_REQ;
            return (n + ffa_pkg::ROUND_ADD) & ~32'd3;
        endfunction

        function int unsigned find_fit(int unsigned need);
            int unsigned x;
            x = head;
            while (x != NIL) begin
                if (blk_size[x] >= need) return x;
                x = link_next[x];
            end
            return NIL;
        endfunction

        function void release_blk(int unsigned off);
            int unsigned b, cur, succ, p, s, t;
            bit merged;
            b = off >> 2;
            merged = 0;
            succ = off + blk_size[b];
            cur = b;
            if (off != 0) begin
                p = phys_prev[b];
                if (!in_use[p]) begin
                    blk_size[p] += blk_size[b];
                    if (succ < heap_bytes) phys_prev[succ >> 2] = p;
                    is_start[b] = 0;
                    cur = p;
                    merged = 1;
                end
            end
            if (!merged) begin
                append(b);
                in_use[b] = 0;
                cur = b;
            end
            if (succ < heap_bytes) begin
                s = succ >> 2;
                if (!in_use[s]) begin
                    t = succ + blk_size[s];
                    if (t < heap_bytes) phys_prev[t >> 2] = cur;
                    blk_size[cur] += blk_size[s];
                    unlink(s);
                    is_start[s] = 0;
                end
            end
        endfunction

        function void note_input(logic [1:0] op, logic [15:0] arg);
            int unsigned need, b, off, nb, nsize, after;
            logic [15:0] pay;
            logic        ok;
            pay = '0;
            ok = 1'b0;
            case (op)
                ffa_pkg::OP_ALLOC: begin
                    need = size_for(arg);
                    b = find_fit(need);
                    if (b != NIL) begin
                        off = b << 2;
                        if (blk_size[b] - need > ffa_pkg::SPLIT_SLACK) begin
                            nb = (off + need) >> 2;
                            nsize = blk_size[b] - need;
                            after = off + need + nsize;
                            phys_prev[nb] = b;
                            blk_size[nb] = nsize;
                            in_use[nb] = 0;
                            is_start[nb] = 1;
                            if (after < heap_bytes) phys_prev[after >> 2] = nb;
                            append(nb);
                            blk_size[b] = need;
                        end
                        unlink(b);
                        in_use[b] = 1;
                        pay = 16'(off + ffa_pkg::HDR_BYTES);
                        ok = 1'b1;
                        live.push_back(off + ffa_pkg::HDR_BYTES);
                    end
                end
                ffa_pkg::OP_FREE: begin
                    if (arg >= ffa_pkg::HDR_BYTES) begin
                        off = arg - ffa_pkg::HDR_BYTES;
                        if ((off & 3) == 0 && off < heap_bytes &&
                            is_start[off >> 2] && in_use[off >> 2]) begin
                            release_blk(off);
                            ok = 1'b1;
                            foreach (live[i]) begin
                                if (live[i] == arg) begin
                                    live.delete(i);
                                    break;
                                end
                            end
                        end
                    end
                end
                ffa_pkg::OP_QUERY: ok = (find_fit(size_for(arg)) != NIL);
                default: ;
            endcase
            pending.push_back({ok, pay});
        endfunction

        function void check_result(logic [23:0] d);
            logic [16:0] want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", d);
                return;
            end
            want = pending.pop_front();
            if (d[16:0] !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: offset exp %0d got %0d, ok exp %0b got %0b",
                             want[15:0], d[15:0], want[16], d[16]);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data;

    heap_scoreboard sb;
    bit quiet;
    int cycles;
    int stall_left;

    first_fit_heap_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: sample at rising edge, stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    task automatic send_word(logic [1:0] op, logic [15:0] arg);
        if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = arg;
        s_axis_tuser = op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, arg);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_heap(logic [16:0] v);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_heap(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_words(int n);
        int r;
        logic [15:0] arg;
        repeat (n) begin
            r = $urandom_range(0, 99);
            arg = $urandom_range(0, 4) == 0 ? 16'($urandom_range(0, 2000)) :
                  16'($urandom_range(0, 64));
            if ($urandom_range(0, 19) == 0) arg = 16'($urandom);
            if (r < 45) begin
                send_word(ffa_pkg::OP_ALLOC, arg);
            end else if (r < 75 && sb.live.size() > 0) begin
                send_word(ffa_pkg::OP_FREE,
                          16'(sb.live[$urandom_range(0, sb.live.size() - 1)]));
            end else if (r < 85) begin
                send_word(ffa_pkg::OP_QUERY, arg);
            end else if (r < 95) begin
                send_word(ffa_pkg::OP_FREE, $urandom_range(0, 1) ? 16'($urandom) : arg);
            end else begin
                send_word(OP_BAD, 16'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        quiet = 0;
        cycles = 0;
        stall_left = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(ffa_pkg::OP_QUERY, 16'hFFFF);
        send_word(ffa_pkg::OP_ALLOC, 16'hFFFF);
        send_word(ffa_pkg::OP_QUERY, 16'd0);
        send_word(ffa_pkg::OP_ALLOC, 16'd0);
        send_word(ffa_pkg::OP_ALLOC, 16'd9);
        send_word(ffa_pkg::OP_ALLOC, 16'd100);
        send_word(ffa_pkg::OP_ALLOC, 16'd8);
        send_word(ffa_pkg::OP_FREE, 16'd0);
        send_word(ffa_pkg::OP_FREE, 16'd13);
        send_word(ffa_pkg::OP_FREE, 16'hFFFF);
        send_word(ffa_pkg::OP_FREE, 16'd40);
        send_word(ffa_pkg::OP_FREE, 16'd12);
        send_word(ffa_pkg::OP_FREE, 16'd12);
        send_word(ffa_pkg::OP_FREE, 16'd36);
        send_word(ffa_pkg::OP_FREE, 16'd24);
        send_word(OP_BAD, 16'hFFFF);
        send_word(OP_BAD, 16'h0000);
        send_word(ffa_pkg::OP_ALLOC, 16'd65000);
        send_word(ffa_pkg::OP_QUERY, 16'd600);
        send_word(ffa_pkg::OP_ALLOC, 16'hAAAA);
        random_words(230);

        write_heap(17'd0);
        send_word(ffa_pkg::OP_ALLOC, 16'd8);
        send_word(ffa_pkg::OP_ALLOC, 16'd0);
        send_word(ffa_pkg::OP_FREE, 16'd12);
        random_words(40);

        write_heap(17'd200);
        random_words(150);

        write_heap(17'h1FFFF);
        send_word(ffa_pkg::OP_ALLOC, 16'hFFF0);
        send_word(ffa_pkg::OP_ALLOC, 16'd65500);
        random_words(240);

        write_heap(17'd1000);
        random_words(160);
        quiet = 1;
        random_words(100);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
